### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
// expects i_clk and the active-low synchronous reset i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define LBBT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lbbt assertion failed");

// next-cycle implication, checked out of reset
`define LBBT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lbbt assertion failed");

`endif

### hw/rtl/lbbt_pkg.sv
// shared types, widths and codes of the label bounding box tracker
// no dependencies
package lbbt_pkg;

    localparam int MAX_LABELS = 1024;
    localparam int MAX_DIM    = 4096;

    localparam int LABEL_W    = $clog2(MAX_LABELS);
    localparam int LCNT_W     = LABEL_W + 1;
    localparam int COORD_W    = $clog2(MAX_DIM);
    localparam int DIM_W      = COORD_W + 1;
    localparam int DIM_LIMIT  = MAX_DIM - 1;
    localparam int EPOCH_W    = 8;
    localparam int REQ_W      = 2;
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;
    localparam logic [CFG_IDX_W-1:0] CFG_LABEL_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [LCNT_W-1:0] LABEL_COUNT_RST  = LCNT_W'(1024);
    localparam logic [DIM_W-1:0]  IMAGE_WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0]  IMAGE_HEIGHT_RST = DIM_W'(480);

    // request codes
    localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START = 2'd2;

    // one bounds entry, tag marks the frame it belongs to
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [COORD_W-1:0] max_row;
        logic [COORD_W-1:0] max_col;
        logic [COORD_W-1:0] min_row;
        logic [COORD_W-1:0] min_col;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [DIM_W-1:0]        box_x;
        logic [DIM_W-1:0]        box_y;
        logic signed [DIM_W-1:0] box_width;
        logic signed [DIM_W-1:0] box_height;
        logic                    label_seen;
        logic                    status;
    } t_box;

endpackage

### hw/rtl/lbbt_req_if.sv
// request channel of the label bounding box tracker
// depends on lbbt_pkg
interface lbbt_req_if;
    import lbbt_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [LABEL_W-1:0] pixel_label;
    logic [LABEL_W-1:0] query_label;

    modport source (output valid, req_type, pixel_label, query_label, input ready);
    modport sink   (input valid, req_type, pixel_label, query_label, output ready);
endinterface

### hw/rtl/lbbt_box_if.sv
// result channel of the label bounding box tracker
// depends on lbbt_pkg
interface lbbt_box_if;
    import lbbt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [DIM_W-1:0]        box_x;
    logic [DIM_W-1:0]        box_y;
    logic signed [DIM_W-1:0] box_width;
    logic signed [DIM_W-1:0] box_height;
    logic                    label_seen;
    logic                    status;

    modport source (output valid, box_x, box_y, box_width, box_height, label_seen, status,
                    input ready);
    modport sink   (input valid, box_x, box_y, box_width, box_height, label_seen, status,
                    output ready);
endinterface

### hw/rtl/lbbt_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module lbbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read during write returns the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/label_bounding_box_tracker.sv
// label bounding box tracker: per-label min/max column and row of a labeled raster
// depends on lbbt_pkg, lbbt_req_if, lbbt_box_if, lbbt_ram and assert_macros.svh
//
// usage
// - i_req carries one item per handshake: a pixel label (raster order, the block
//   counts column and row itself), a bounds read for query_label, or a start of frame
// - o_box returns one item per bounds read, in request order; pixels and frame
//   starts return nothing
// - i_cfg_we/i_cfg_idx/i_cfg_data write label_count, image_width, image_height;
//   write only while no item is in flight
// - a read accepted on i_req passes the merge stage and the result queue before it shows on o_box
// - throughput: one item per cycle while i_req.ready is high, set by the single read-modify-write
//   pass through the bounds memory (registered read, then merge and write back)
// - reset: counters and registers go to defaults, then a clearing pass over all 1024
//   memory entries tags each as stale; i_req.ready stays low meanwhile,
//   config writes are taken as ever
// - each frame start bumps an 8-bit frame tag; after 255 frame starts the tag
//   wraps and the same clearing pass runs again
// - a stalled o_box backs up into a three-item result queue; i_req.ready drops
//   once queued results plus a read in the merge stage reach three; nothing is lost
`include "assert_macros.svh"

module label_bounding_box_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lbbt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lbbt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    lbbt_req_if.sink                          i_req,
    lbbt_box_if.source                        o_box
);
    import lbbt_pkg::*;

    // configuration registers
    logic [LCNT_W-1:0] r_label_count;
    logic [DIM_W-1:0]  r_image_width;
    logic [DIM_W-1:0]  r_image_height;

    // raster position and frame tag
    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;

    // clearing pass
    logic               r_clr_busy, n_clr_busy;
    logic [LABEL_W-1:0] r_clr_addr, n_clr_addr;

    // merge stage
    logic               r_s1_valid;
    logic [REQ_W-1:0]   r_s1_req;
    logic [LABEL_W-1:0] r_s1_lab;
    logic               r_s1_inrng;
    logic [COORD_W-1:0] r_s1_col;
    logic [COORD_W-1:0] r_s1_row;

    // last memory write, for the back-to-back same-label case
    logic               r_fwd_valid;
    logic [LABEL_W-1:0] r_fwd_addr;
    t_entry             r_fwd_data;

    // result queue
    t_box               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_CW-1:0] r_cnt;

    logic               w_acc;
    logic               w_ready;
    logic [LABEL_W-1:0] w_lab;
    logic               w_in_range;
    logic [DIM_W-1:0]   w_next_col;
    logic [DIM_W-1:0]   w_next_row;
    logic               w_s1_read;
    logic [FIFO_CW:0]   w_occ;

    logic               w_ram_we;
    logic [LABEL_W-1:0] w_ram_waddr;
    t_entry             w_ram_wdata;
    logic [ENTRY_W-1:0] w_ram_rdata;

    t_entry             w_cur;
    logic               w_seen;
    logic               w_s1_we;
    t_entry             w_merged;
    t_box               w_res;
    logic               w_push;
    logic               w_pop;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_count  <= LABEL_COUNT_RST;
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LABEL_COUNT:  r_label_count  <= i_cfg_data[LCNT_W-1:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- intake
    // room for one more result even if the merge stage holds a read
    assign w_s1_read = r_s1_valid && (r_s1_req == REQ_READ);
    assign w_occ     = {1'b0, r_cnt} + {{FIFO_CW{1'b0}}, w_s1_read};
    assign w_ready   = !r_clr_busy && (w_occ < (FIFO_CW + 1)'(FIFO_DEPTH));
    assign i_req.ready = w_ready;
    assign w_acc     = i_req.valid && w_ready;

    assign w_lab      = (i_req.req_type == REQ_PIXEL) ? i_req.pixel_label : i_req.query_label;
    assign w_in_range = {1'b0, w_lab} < r_label_count;

    // raster position, frame tag and clearing pass
    assign w_next_col = {1'b0, r_col} + DIM_W'(1);
    assign w_next_row = {1'b0, r_row} + DIM_W'(1);

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_epoch    = r_epoch;
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + LABEL_W'(1);
            if (r_clr_addr == LABEL_W'(MAX_LABELS - 1)) begin
                n_clr_busy = 1'b0;
            end
        end
        if (w_acc) begin
            case (i_req.req_type)
                REQ_PIXEL: begin
                    if (w_next_col >= r_image_width || w_next_col >= DIM_W'(DIM_LIMIT)) begin
                        n_col = '0;
                        if (w_next_row >= r_image_height ||
                            w_next_row >= DIM_W'(DIM_LIMIT)) begin
                            n_row = '0;
                        end else begin
                            n_row = w_next_row[COORD_W-1:0];
                        end
                    end else begin
                        n_col = w_next_col[COORD_W-1:0];
                    end
                end
                REQ_START: begin
                    n_col = '0;
                    n_row = '0;
                    // tag wrap: stale tags could match again, sweep them out
                    if (r_epoch == '1) begin
                        n_epoch    = EPOCH_W'(1);
                        n_clr_busy = 1'b1;
                        n_clr_addr = '0;
                    end else begin
                        n_epoch = r_epoch + EPOCH_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_epoch    <= EPOCH_W'(1);
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_epoch    <= n_epoch;
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
            r_s1_valid <= w_acc;
        end
    end

    // merge stage payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_req   <= i_req.req_type;
            r_s1_lab   <= w_lab;
            r_s1_inrng <= w_in_range;
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
        end
    end

    // ---------------------------------------------------------------- memory
    // tag 0 never matches a live frame, so the clearing pass writes zeros
    assign w_ram_we    = r_clr_busy || w_s1_we;
    assign w_ram_waddr = r_clr_busy ? r_clr_addr : r_s1_lab;
    assign w_ram_wdata = r_clr_busy ? t_entry'('0) : w_merged;

    lbbt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LABELS)
    ) u_bounds_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_lab),
        .o_rdata (w_ram_rdata)
    );

    // memory read at the same edge as the previous write sees old data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= w_ram_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= w_ram_waddr;
        r_fwd_data <= w_ram_wdata;
    end

    // ---------------------------------------------------------------- merge
    assign w_cur  = (r_fwd_valid && r_fwd_addr == r_s1_lab) ? r_fwd_data : t_entry'(w_ram_rdata);
    assign w_seen = (w_cur.tag == r_epoch);

    // background and out-of-range pixels update nothing
    assign w_s1_we = r_s1_valid && (r_s1_req == REQ_PIXEL) && r_s1_inrng &&
                     (r_s1_lab != '0);

    always_comb begin
        w_merged.tag = r_epoch;
        if (!w_seen) begin
            w_merged.min_col = r_s1_col;
            w_merged.max_col = r_s1_col;
            w_merged.min_row = r_s1_row;
            w_merged.max_row = r_s1_row;
        end else begin
            w_merged.min_col = (r_s1_col < w_cur.min_col) ? r_s1_col : w_cur.min_col;
            w_merged.max_col = (r_s1_col > w_cur.max_col) ? r_s1_col : w_cur.max_col;
            w_merged.min_row = (r_s1_row < w_cur.min_row) ? r_s1_row : w_cur.min_row;
            w_merged.max_row = (r_s1_row > w_cur.max_row) ? r_s1_row : w_cur.max_row;
        end
    end

    // read result
    always_comb begin
        w_res = '0;
        if (!r_s1_inrng) begin
            w_res.status = 1'b1;
        end else if (r_s1_lab == '0) begin
            // background: image minus a one-pixel border
            w_res.box_x      = DIM_W'(1);
            w_res.box_y      = DIM_W'(1);
            w_res.box_width  = $signed(r_image_width - DIM_W'(2));
            w_res.box_height = $signed(r_image_height - DIM_W'(2));
        end else if (!w_seen) begin
            w_res.box_x      = r_image_width;
            w_res.box_y      = r_image_height;
            w_res.box_width  = $signed(DIM_W'(0) - r_image_width);
            w_res.box_height = $signed(DIM_W'(0) - r_image_height);
        end else begin
            w_res.box_x      = {1'b0, w_cur.min_col};
            w_res.box_y      = {1'b0, w_cur.min_row};
            w_res.box_width  = $signed({1'b0, w_cur.max_col} - {1'b0, w_cur.min_col});
            w_res.box_height = $signed({1'b0, w_cur.max_row} - {1'b0, w_cur.min_row});
            w_res.label_seen = 1'b1;
        end
    end

    // ---------------------------------------------------------------- results
    assign w_push = w_s1_read;
    assign w_pop  = o_box.valid && o_box.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wp + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rp + FIFO_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + FIFO_CW'(1);
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - FIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp] <= w_res;
        end
    end

    assign o_box.valid      = (r_cnt != '0);
    assign o_box.box_x      = r_fifo[r_rp].box_x;
    assign o_box.box_y      = r_fifo[r_rp].box_y;
    assign o_box.box_width  = r_fifo[r_rp].box_width;
    assign o_box.box_height = r_fifo[r_rp].box_height;
    assign o_box.label_seen = r_fifo[r_rp].label_seen;
    assign o_box.status     = r_fifo[r_rp].status;

    // ---------------------------------------------------------------- checks
    // a pixel write-back never collides with the clearing pass
    `LBBT_ASSERT_IMP(a_clr_excl, w_s1_we, !r_clr_busy)
    // the queue always has room for a result leaving the merge stage
    `LBBT_ASSERT_IMP(a_no_overflow, w_push, (r_cnt < FIFO_CW'(FIFO_DEPTH)) || w_pop)
    // a frame start at the last tag value starts a clearing pass
    `LBBT_ASSERT_NXT(a_wrap_clear, w_acc && (i_req.req_type == REQ_START) && (r_epoch == '1),
                     r_clr_busy && (r_clr_addr == '0) && (r_epoch == EPOCH_W'(1)))

endmodule

### test/tb_label_bounding_box_tracker.sv
// self-checking testbench of label_bounding_box_tracker: pixel, bounds read and frame start
// items in, bounds items checked against an in-bench tracker model
// depends on lbbt_pkg, lbbt_req_if, lbbt_box_if and the block itself
module tb_label_bounding_box_tracker;
    import lbbt_pkg::*;

    // unused request code, the block must swallow it without a result
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    // hard stop, far above the slowest legal run
    localparam int CYCLE_LIMIT = 100_000;
    // a read item passes the merge stage and the result queue before it can be taken, give it some slack
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [REQ_W-1:0]   kind;
        logic [LABEL_W-1:0] pix;
        logic [LABEL_W-1:0] qry;
    } req_item_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lbbt_req_if req_ch ();
    lbbt_box_if box_ch ();

    label_bounding_box_tracker DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_box      (box_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // items waiting to be driven and bounds items waiting to come back
    req_item_t pending_reqs [$];
    t_box      pending_boxes [$];
    req_item_t drive_item;
    t_box      want_box;
    int        mismatch_count = 0;
    int        cycle_count = 0;
    // when set, neither side inserts bubbles
    bit        steady_flow = 1'b0;

    // tracker model: per-label bounds, seen bits, raster position and registers
    logic [COORD_W-1:0] col_lo [MAX_LABELS];
    logic [COORD_W-1:0] col_hi [MAX_LABELS];
    logic [COORD_W-1:0] row_lo [MAX_LABELS];
    logic [COORD_W-1:0] row_hi [MAX_LABELS];
    bit                 label_hit [MAX_LABELS];
    logic [COORD_W-1:0] cur_col;
    logic [COORD_W-1:0] cur_row;
    logic [LCNT_W-1:0]  lbl_limit;
    logic [DIM_W-1:0]   img_w;
    logic [DIM_W-1:0]   img_h;

    // update the model with one accepted item, queue the bounds item a read gives
    function automatic void track_request(req_item_t it);
        t_box box;
        int   next_col;
        int   next_row;
        box = '0;
        case (it.kind)
            REQ_PIXEL: begin
                // background and labels past the count are not tracked
                if (it.pix != '0 && it.pix < lbl_limit) begin
                    if (!label_hit[it.pix]) begin
                        label_hit[it.pix] = 1'b1;
                        col_lo[it.pix] = cur_col;
                        col_hi[it.pix] = cur_col;
                        row_lo[it.pix] = cur_row;
                        row_hi[it.pix] = cur_row;
                    end else begin
                        if (cur_col < col_lo[it.pix]) col_lo[it.pix] = cur_col;
                        if (cur_col > col_hi[it.pix]) col_hi[it.pix] = cur_col;
                        if (cur_row < row_lo[it.pix]) row_lo[it.pix] = cur_row;
                        if (cur_row > row_hi[it.pix]) row_hi[it.pix] = cur_row;
                    end
                end
                // raster advance, both counters also stop short of the coordinate limit
                next_col = int'(cur_col) + 1;
                if (next_col >= int'(img_w) || next_col >= DIM_LIMIT) begin
                    cur_col = '0;
                    next_row = int'(cur_row) + 1;
                    if (next_row >= int'(img_h) || next_row >= DIM_LIMIT) cur_row = '0;
                    else cur_row = COORD_W'(next_row);
                end else begin
                    cur_col = COORD_W'(next_col);
                end
            end
            REQ_START: begin
                foreach (label_hit[i]) label_hit[i] = 1'b0;
                cur_col = '0;
                cur_row = '0;
            end
            REQ_READ: begin
                if (it.qry >= lbl_limit) begin
                    box.status = 1'b1;
                end else if (it.qry == '0) begin
                    // background answers the image minus its border
                    box.box_x = DIM_W'(1);
                    box.box_y = DIM_W'(1);
                    box.box_width = img_w - DIM_W'(2);
                    box.box_height = img_h - DIM_W'(2);
                end else if (!label_hit[it.qry]) begin
                    // unseen label gives an inverted box
                    box.box_x = img_w;
                    box.box_y = img_h;
                    box.box_width = DIM_W'(0) - img_w;
                    box.box_height = DIM_W'(0) - img_h;
                end else begin
                    box.box_x = DIM_W'(col_lo[it.qry]);
                    box.box_y = DIM_W'(row_lo[it.qry]);
                    box.box_width = DIM_W'(col_hi[it.qry]) - DIM_W'(col_lo[it.qry]);
                    box.box_height = DIM_W'(row_hi[it.qry]) - DIM_W'(row_lo[it.qry]);
                    box.label_seen = 1'b1;
                end
                pending_boxes.push_back(box);
            end
            default: ;
        endcase
    endfunction

    function automatic void compare_field(string name, logic [DIM_W-1:0] want_v,
                                          logic [DIM_W-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t %s mismatch: expected %0d (0x%h) got %0d (0x%h)",
                     $time, name, want_v, want_v, got_v, got_v);
            mismatch_count++;
        end
    endfunction

    // driver: one item per handshake, random bubbles unless steady_flow
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                track_request('{kind: req_ch.req_type, pix: req_ch.pixel_label,
                                qry: req_ch.query_label});
            // a held item stays put until the block takes it
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_reqs.size() > 0 && (steady_flow || $urandom_range(99) >= 22)) begin
                    drive_item = pending_reqs.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.req_type <= drive_item.kind;
                    req_ch.pixel_label <= drive_item.pix;
                    req_ch.query_label <= drive_item.qry;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, every bounds item checked in order
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            box_ch.ready <= 1'b0;
        end else begin
            if (box_ch.valid && box_ch.ready) begin
                if (pending_boxes.size() == 0) begin
                    $display("%0t bounds item with none expected: x %0d y %0d w %0d h %0d",
                             $time, box_ch.box_x, box_ch.box_y, box_ch.box_width,
                             box_ch.box_height);
                    mismatch_count++;
                end else begin
                    want_box = pending_boxes.pop_front();
                    compare_field("box_x", want_box.box_x, box_ch.box_x);
                    compare_field("box_y", want_box.box_y, box_ch.box_y);
                    compare_field("box_width", want_box.box_width, box_ch.box_width);
                    compare_field("box_height", want_box.box_height, box_ch.box_height);
                    compare_field("label_seen", DIM_W'(want_box.label_seen),
                                  DIM_W'(box_ch.label_seen));
                    compare_field("status", DIM_W'(want_box.status), DIM_W'(box_ch.status));
                end
            end
            box_ch.ready <= steady_flow || ($urandom_range(99) >= 22);
        end
    end

    // watchdog, also covers the clearing passes after reset and tag wrap
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout with %0d items still expected", $time, pending_boxes.size());
            $display("[label_bounding_box_tracker] ERROR");
            $finish;
        end
    end

    function automatic void push_item(logic [REQ_W-1:0] kind, logic [LABEL_W-1:0] pix,
                                      logic [LABEL_W-1:0] qry);
        pending_reqs.push_back('{kind: kind, pix: pix, qry: qry});
    endfunction

    // block until nothing is in flight, then let the pipeline settle
    // sampled mid-cycle so the driver and monitor updates of the edge are visible
    task automatic wait_quiet(input int settle);
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || req_ch.valid || pending_boxes.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // register write, only called with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LABEL_COUNT:  lbl_limit = LCNT_W'(value);
            CFG_IMAGE_WIDTH:  img_w = DIM_W'(value);
            CFG_IMAGE_HEIGHT: img_h = DIM_W'(value);
            default: ;
        endcase
    endtask

    // random frames over a small image: mostly start, pixels and reads of a label pool,
    // with some noise items and frames that skip their start
    task automatic random_frames(input int quota);
        logic [LABEL_W-1:0] pool [6];
        int issued;
        int frame_len;
        int roll;
        int pick;
        issued = 0;
        foreach (pool[i])
            pool[i] = (lbl_limit > 1 && $urandom_range(9) > 0) ?
                      LABEL_W'($urandom_range(int'(lbl_limit) - 1, 1)) : LABEL_W'($urandom);
        while (issued < quota) begin
            if ($urandom_range(9) > 0) begin
                push_item(REQ_START, LABEL_W'($urandom), LABEL_W'($urandom));
                issued++;
            end
            frame_len = $urandom_range(int'(img_w) * int'(img_h) + 3, 1);
            for (int p = 0; p < frame_len; p++) begin
                roll = $urandom_range(99);
                pick = $urandom_range(99);
                if (roll < 5) begin
                    push_item(REQ_UNUSED, LABEL_W'($urandom), LABEL_W'($urandom));
                end else if (roll < 22) begin
                    push_item(REQ_READ, LABEL_W'($urandom),
                              pick < 70 ? pool[$urandom_range(5)] :
                              pick < 80 ? LABEL_W'(0) : LABEL_W'($urandom));
                    issued++;
                end else begin
                    push_item(REQ_PIXEL,
                              pick < 65 ? pool[$urandom_range(5)] :
                              pick < 80 ? LABEL_W'(0) : LABEL_W'($urandom),
                              LABEL_W'($urandom));
                    issued++;
                end
            end
            // close most frames by reading the whole pool
            if ($urandom_range(3) > 0)
                foreach (pool[i]) begin
                    push_item(REQ_READ, LABEL_W'($urandom), pool[i]);
                    issued++;
                end
        end
    endtask

    initial begin
        // every block input known from time zero
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_PIXEL;
        req_ch.pixel_label = '0;
        req_ch.query_label = '0;
        box_ch.ready = 1'b0;

        lbl_limit = LABEL_COUNT_RST;
        img_w = IMAGE_WIDTH_RST;
        img_h = IMAGE_HEIGHT_RST;
        cur_col = '0;
        cur_row = '0;
        foreach (label_hit[i]) label_hit[i] = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults right out of reset
        push_item(REQ_READ, '0, '0);
        push_item(REQ_READ, '0, LABEL_W'(1023));
        wait_quiet(SETTLE_CYCLES);

        // directed: 3x3 image, corner labels, row wrap back to the top
        write_reg(CFG_IMAGE_WIDTH, 3);
        write_reg(CFG_IMAGE_HEIGHT, 3);
        write_reg(CFG_LABEL_COUNT, 1024);
        push_item(REQ_READ, '0, '0);
        push_item(REQ_READ, '0, LABEL_W'(1));
        push_item(REQ_UNUSED, LABEL_W'(1023), LABEL_W'(1023));
        push_item(REQ_PIXEL, LABEL_W'(1023), '0);
        push_item(REQ_PIXEL, LABEL_W'(1), '0);
        push_item(REQ_PIXEL, LABEL_W'(0), '1);
        push_item(REQ_PIXEL, LABEL_W'(1), '0);
        push_item(REQ_PIXEL, LABEL_W'(5), '0);
        push_item(REQ_PIXEL, LABEL_W'(1), '0);
        push_item(REQ_PIXEL, LABEL_W'(1023), '0);
        push_item(REQ_PIXEL, LABEL_W'(1), '0);
        push_item(REQ_PIXEL, LABEL_W'(1), '0);
        // position wrapped, this pixel lands on (0,0) again
        push_item(REQ_PIXEL, LABEL_W'(2), '0);
        push_item(REQ_READ, '1, LABEL_W'(1));
        push_item(REQ_READ, '0, LABEL_W'(1023));
        push_item(REQ_READ, '0, LABEL_W'(5));
        push_item(REQ_READ, '0, LABEL_W'(2));
        push_item(REQ_READ, '0, '0);
        push_item(REQ_START, '1, '1);
        push_item(REQ_READ, '0, LABEL_W'(1));
        push_item(REQ_PIXEL, LABEL_W'(1), '0);
        push_item(REQ_READ, '0, LABEL_W'(1));
        wait_quiet(SETTLE_CYCLES);

        // one label only: everything but background is out of range, mid-frame change
        write_reg(CFG_LABEL_COUNT, 1);
        push_item(REQ_READ, '0, '0);
        push_item(REQ_READ, '0, LABEL_W'(1));
        push_item(REQ_PIXEL, LABEL_W'(1), '0);
        push_item(REQ_READ, '0, LABEL_W'(1023));
        wait_quiet(SETTLE_CYCLES);
        // bounds gathered before the count shrank show again
        write_reg(CFG_LABEL_COUNT, 1024);
        push_item(REQ_READ, '0, LABEL_W'(1));
        wait_quiet(SETTLE_CYCLES);

        // random frames across several register settings, extremes first
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_LABEL_COUNT, ph == 0 ? 1024 : ph == 1 ? 1 :
                      ph == 2 ? 2 : ($urandom_range(1) ? $urandom_range(40, 2) :
                                     $urandom_range(1024, 2)));
            write_reg(CFG_IMAGE_WIDTH, ph == 0 ? 3 : $urandom_range(24, 3));
            write_reg(CFG_IMAGE_HEIGHT, ph == 0 ? 3 : $urandom_range(12, 3));
            random_frames(80);
            wait_quiet(SETTLE_CYCLES);
        end

        // many short frames with no bubbles on either side: the frame tag wraps,
        // a label seen long ago must read unseen
        steady_flow = 1'b1;
        write_reg(CFG_LABEL_COUNT, 1024);
        write_reg(CFG_IMAGE_WIDTH, 5);
        write_reg(CFG_IMAGE_HEIGHT, 4);
        push_item(REQ_START, '0, '0);
        push_item(REQ_PIXEL, LABEL_W'(9), '0);
        push_item(REQ_READ, '0, LABEL_W'(9));
        for (int i = 0; i < 260; i++) begin
            push_item(REQ_START, LABEL_W'($urandom), LABEL_W'($urandom));
            if (i % 8 == 0)
                push_item(REQ_READ, LABEL_W'($urandom), LABEL_W'(5));
            push_item(REQ_PIXEL, LABEL_W'(5), LABEL_W'($urandom));
        end
        push_item(REQ_READ, '0, LABEL_W'(5));
        push_item(REQ_READ, '0, LABEL_W'(9));
        push_item(REQ_READ, '0, '0);

        wait_quiet(8);
        steady_flow = 1'b0;
        if (mismatch_count == 0)
            $display("[label_bounding_box_tracker] OK");
        else
            $display("[label_bounding_box_tracker] ERROR");
        $finish;
    end

endmodule
